>>> rtl/core/mavg_pkg.sv
`default_nettype none

package mavg_pkg;

   // default sizes, handed to the top level parameters
   localparam int WINDOW_MAX_DEF   = 64;
   localparam int SAMPLE_WIDTH_DEF = 16;

   // window length register and sample count share one width
   localparam int COUNT_W = 7;

   // window length after reset, before any register write
   localparam int WINDOW_RESET = 64;

   // command codes carried on req_tuser
   typedef enum logic {
      CMD_PUSH  = 1'b0,
      CMD_CLEAR = 1'b1
   } cmd_type;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_DIVIDE
   } state_type;

endpackage

`default_nettype wire

>>> rtl/core/mavg_ring.sv
`default_nettype none

module mavg_ring
   import mavg_pkg::*;
#(
   parameter int DEPTH  = WINDOW_MAX_DEF,
   parameter int WIDTH  = SAMPLE_WIDTH_DEF,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/core/mavg_div.sv
`default_nettype none

module mavg_div
   import mavg_pkg::*;
#(
   parameter int SUM_W  = SAMPLE_WIDTH_DEF + COUNT_W,
   parameter int QUOT_W = SAMPLE_WIDTH_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic               negative,
   input  wire logic [SUM_W-1:0]   dividend,
   input  wire logic [COUNT_W-1:0] divisor,
   output logic                    done,
   output logic [QUOT_W-1:0]       quotient
);

   localparam int CNT_W = $clog2(SUM_W + 1);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [SUM_W-1:0]   quo_ff, quo_in;
   logic [COUNT_W-1:0] rem_ff, rem_in;
   logic [COUNT_W-1:0] div_ff, div_in;
   logic               neg_ff, neg_in;

   logic [COUNT_W:0]   trial;
   logic [COUNT_W:0]   diff;
   logic [QUOT_W-1:0]  quo_low;

   // one restoring step: shift in the next dividend bit, try subtract
   always_comb begin
      trial = {rem_ff, quo_ff[SUM_W-1]};
      diff  = trial - {1'b0, div_ff};
   end

   // next state of the divider
   always_comb begin
      busy_in = busy_ff;
      done_in = done_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      neg_in  = neg_ff;
      priority if (start) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         cnt_in  = CNT_W'(SUM_W);
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
         neg_in  = negative;
      end else if (busy_ff) begin
         if (trial >= {1'b0, div_ff}) begin
            rem_in = diff[COUNT_W-1:0];
            quo_in = {quo_ff[SUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial[COUNT_W-1:0];
            quo_in = {quo_ff[SUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else begin
         // idle: hold the last quotient until the next start
         busy_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      neg_ff <= neg_in;
   end

   // magnitude quotient back to a signed result, truncated toward zero
   assign quo_low  = quo_ff[QUOT_W-1:0];
   assign quotient = neg_ff ? (~quo_low + QUOT_W'(1)) : quo_low;
   assign done     = done_ff;

endmodule

`default_nettype wire

>>> rtl/core/moving_average_filter_core.sv
`default_nettype none

// channel   | dir | tdata (low bit up)                    | tuser
// ----------+-----+---------------------------------------+------------------------
// req_      | in  | sample                                | command (0 push, 1 clear)
// rsp_      | out | mean, samples_held                    | -
// csr_      | in  | window_length (csr_wdata)             | -
//
// a push word runs from accept to the next accept through a ring read, an
// update step, the restoring divider over the SAMPLE_WIDTH + COUNT_W bits
// of the sum, and a load of the output register
// a clear word is taken in the idle state and gives no result
// reset leaves the ring contents as they are; the fill count masks them
// a new word is accepted while a result waits in the output register; the
// divider holds its result until that register is free

module moving_average_filter_core
   import mavg_pkg::*;
#(
   parameter  int WINDOW_MAX   = WINDOW_MAX_DEF,
   parameter  int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
   localparam int IN_DATA_W    = ((SAMPLE_WIDTH + 7) / 8) * 8,
   localparam int OUT_DATA_W   = ((SAMPLE_WIDTH + COUNT_W + 7) / 8) * 8
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request channel
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [IN_DATA_W-1:0]  req_tdata,   // sample
   input  wire logic                  req_tuser,   // command
   // response channel
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [OUT_DATA_W-1:0]      rsp_tdata,   // mean, samples_held
   // window length register
   input  wire logic                  csr_wen,
   input  wire logic [COUNT_W-1:0]    csr_wdata
);

   localparam int SUM_W  = SAMPLE_WIDTH + COUNT_W;
   localparam int SLOT_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int WIN_RESET = (WINDOW_RESET > WINDOW_MAX) ? WINDOW_MAX : WINDOW_RESET;

   state_type state_ff, state_in;

   logic [COUNT_W-1:0]      window_ff, window_in;
   logic [SLOT_W-1:0]       slot_ff, slot_in;
   logic [COUNT_W-1:0]      fill_ff, fill_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic signed [SAMPLE_WIDTH-1:0] sample_ff;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_WIDTH-1:0] mean_ff;
   logic [COUNT_W-1:0]      held_ff;

   logic                    req_accept;
   logic                    is_clear;
   logic                    do_update;
   logic                    load_out;
   logic                    div_done;
   logic [SAMPLE_WIDTH-1:0] div_quotient;

   logic signed [SAMPLE_WIDTH-1:0] ring_rd_data;
   logic signed [SAMPLE_WIDTH-1:0] old_sample;
   logic signed [SUM_W-1:0]        sum_upd;
   logic [SUM_W-1:0]               sum_mag;
   logic [31:0]                    slot_plus;
   logic [COUNT_W-1:0]             fill_upd;
   logic [COUNT_W-1:0]             csr_clamped;

   assign req_accept = req_tvalid && req_tready;
   assign is_clear   = (cmd_type'(req_tuser) == CMD_CLEAR);

   // sample ring
   mavg_ring #(
      .DEPTH  (WINDOW_MAX),
      .WIDTH  (SAMPLE_WIDTH),
      .ADDR_W (SLOT_W)
   ) u_ring (
      .clock   (clock),
      .rd_en   (req_accept),
      .rd_addr (slot_ff),
      .rd_data (ring_rd_data),
      .wr_en   (do_update),
      .wr_addr (slot_ff),
      .wr_data (sample_ff)
   );

   // slot not yet written since the last clear while the window is filling
   assign old_sample = (fill_ff < window_ff) ? '0 : ring_rd_data;

   // running sum and pointer update
   always_comb begin
      sum_upd   = sum_ff - SUM_W'(old_sample) + SUM_W'(sample_ff);
      sum_mag   = sum_upd[SUM_W-1] ? (~sum_upd + SUM_W'(1)) : sum_upd;
      slot_plus = 32'(slot_ff) + 32'd1;
      fill_upd  = (fill_ff < window_ff) ? (fill_ff + COUNT_W'(1)) : fill_ff;
   end

   // window length write, zero taken as one, saturated at the ring depth
   always_comb begin
      priority if (csr_wdata == '0) begin
         csr_clamped = COUNT_W'(1);
      end else if (32'(csr_wdata) > 32'(WINDOW_MAX)) begin
         csr_clamped = COUNT_W'(WINDOW_MAX);
      end else begin
         csr_clamped = csr_wdata;
      end
   end

   // restoring divider by the fill count
   mavg_div #(
      .SUM_W  (SUM_W),
      .QUOT_W (SAMPLE_WIDTH)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (do_update),
      .negative (sum_upd[SUM_W-1]),
      .dividend (sum_mag),
      .divisor  (fill_upd),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // sequencer next state and outputs
   always_comb begin
      state_in     = state_ff;
      req_tready   = 1'b0;
      do_update    = 1'b0;
      load_out     = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_accept && !is_clear) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            do_update = 1'b1;
            state_in  = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (div_done && (!rsp_valid_ff || rsp_tready)) begin
               load_out     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // filter state next values
   always_comb begin
      window_in = window_ff;
      slot_in   = slot_ff;
      fill_in   = fill_ff;
      sum_in    = sum_ff;
      priority if (csr_wen) begin
         window_in = csr_clamped;
         slot_in   = '0;
         fill_in   = '0;
         sum_in    = '0;
      end else if (req_accept && is_clear) begin
         slot_in = '0;
         fill_in = '0;
         sum_in  = '0;
      end else if (do_update) begin
         slot_in = (slot_plus >= 32'(window_ff)) ? '0 : slot_plus[SLOT_W-1:0];
         fill_in = fill_upd;
         sum_in  = sum_upd;
      end else begin
         // nothing to do this cycle
         window_in = window_ff;
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         window_ff    <= COUNT_W'(WIN_RESET);
         slot_ff      <= '0;
         fill_ff      <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         window_ff    <= window_in;
         slot_ff      <= slot_in;
         fill_ff      <= fill_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // input sample and output word registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         sample_ff <= req_tdata[SAMPLE_WIDTH-1:0];
      end
      if (load_out) begin
         mean_ff <= div_quotient;
         held_ff <= fill_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = OUT_DATA_W'({held_ff, mean_ff});

endmodule

`default_nettype wire

>>> test/tb_top.sv
`timescale 1ns / 100ps

module tb_top
   import mavg_pkg::*;
();

   localparam int WIN_MAX      = WINDOW_MAX_DEF;
   localparam int DRAIN_CYCLES = 40;

   // one expected output word
   typedef struct packed {
      logic signed [15:0] mean;
      logic [COUNT_W-1:0] held;
   } mean_result_type;

   logic                clock;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [15:0]         req_tdata  = '0;   // sample
   logic                req_tuser  = CMD_PUSH;   // command
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [23:0]         rsp_tdata;   // mean, samples_held, pad
   logic                csr_wen    = 1'b0;
   logic [COUNT_W-1:0]  csr_wdata  = '0;

   // averaging state mirrored from the block
   logic signed [15:0]  ring_model [WIN_MAX];
   int unsigned         slot_model;
   int unsigned         fill_model;
   int unsigned         win_model;
   int                  sum_model;
   mean_result_type     mean_q [$];

   // traffic shaping
   int                  send_gap_pct = 0;
   int                  rsp_gap_pct  = 0;
   int                  hold_left    = 0;
   int                  burst_left   = 0;
   logic signed [15:0]  burst_val    = '0;

   // tallies
   int                  err_count     = 0;
   int                  words_sent    = 0;
   int                  clears_sent   = 0;
   int                  results_seen  = 0;
   int                  settings_used = 0;

   moving_average_filter_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // zero the averaging state
   function automatic void clear_model();
      for (int i = 0; i < WIN_MAX; i++) ring_model[i] = '0;
      slot_model = 0;
      fill_model = 0;
      sum_model  = 0;
   endfunction

   // window length write, clamped to 1..WIN_MAX, clears state
   function automatic void apply_window(logic [COUNT_W-1:0] v);
      int unsigned w;
      w = v;
      if (w == 0) w = 1;
      if (w > WIN_MAX) w = WIN_MAX;
      win_model = w;
      clear_model();
   endfunction

   // one accepted word: clear zeroes the state, push updates the running sum and queues the mean
   function automatic void average_step(cmd_type cmd, logic signed [15:0] smp);
      mean_result_type res;
      int unsigned     at;
      if (cmd == CMD_CLEAR) begin
         clear_model();
         return;
      end
      at = slot_model;
      if (at >= win_model) at = 0;
      sum_model = sum_model - int'(ring_model[at]) + int'(smp);
      ring_model[at] = smp;
      at++;
      if (at >= win_model) at = 0;
      slot_model = at;
      if (fill_model < win_model) fill_model++;
      res.mean = 16'(sum_model / int'(fill_model));
      res.held = COUNT_W'(fill_model);
      mean_q.push_back(res);
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      err_count++;
      if (err_count <= 40)
         $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $time);
   endtask

   // send one word, with an optional gap ahead of it
   task automatic send_word(cmd_type cmd, logic signed [15:0] smp);
      if (send_gap_pct > 0 && $urandom_range(99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 30)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= smp;
      do @(posedge clock); while (!req_tready);
      words_sent++;
      if (cmd == CMD_CLEAR) clears_sent++;
      average_step(cmd, smp);
   endtask

   // stop offering and let every pending mean come out
   task automatic wait_drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (mean_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_window(logic [COUNT_W-1:0] v);
      wait_drain();
      csr_wen   <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_wen   <= 1'b0;
      apply_window(v);
      settings_used++;
   endtask

   // result side: check each accepted word, then pick the next ready
   initial begin : rsp_side
      mean_result_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (mean_q.size() == 0) begin
               report_mismatch("unexpected word, mean", $signed(rsp_tdata[15:0]), 0);
            end else begin
               want = mean_q.pop_front();
               if (rsp_tdata[15:0] !== want.mean)
                  report_mismatch("mean", $signed(rsp_tdata[15:0]), want.mean);
               if (rsp_tdata[22:16] !== want.held)
                  report_mismatch("samples_held", rsp_tdata[22:16], want.held);
            end
         end
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rsp_gap_pct);
         end
      end
   end

   // extremes of the sample, truncation toward zero, clear at default window
   task automatic test_sample_extremes();
      send_word(CMD_PUSH, 16'sh7fff);
      send_word(CMD_PUSH, 16'sh7fff);
      send_word(CMD_PUSH, 16'sh8000);
      send_word(CMD_PUSH, 16'sh8000);
      send_word(CMD_PUSH, -16'sd1);
      send_word(CMD_PUSH, 16'sd1);
      send_word(CMD_CLEAR, 16'sh5a5a);
      send_word(CMD_PUSH, -16'sd7);
      send_word(CMD_PUSH, 16'sd2);
   endtask

   // window register: zero, out of range, and a short wrapping window
   task automatic test_window_register();
      write_window(7'd0);
      send_word(CMD_PUSH, 16'sh8000);
      send_word(CMD_PUSH, 16'sh7fff);
      write_window(7'd127);
      send_word(CMD_PUSH, 16'sd3);
      write_window(7'd65);
      send_word(CMD_PUSH, -16'sd3);
      write_window(7'd3);
      send_word(CMD_PUSH, 16'sd10);
      send_word(CMD_PUSH, 16'sd20);
      send_word(CMD_PUSH, 16'sd30);
      send_word(CMD_PUSH, 16'sd40);
      send_word(CMD_PUSH, -16'sd100);
      send_word(CMD_CLEAR, 16'sd0);
      send_word(CMD_PUSH, 16'sd9);
   endtask

   // receiver stalls for a long stretch while words keep coming
   task automatic test_backpressure();
      write_window(7'd64);
      hold_left = 300;
      for (int i = 0; i < 8; i++) send_word(CMD_PUSH, 16'($urandom));
      wait_drain();
   endtask

   function automatic logic [COUNT_W-1:0] pick_window();
      case ($urandom_range(5))
         0:       return 7'd0;
         1:       return 7'd1;
         2:       return 7'd64;
         3:       return 7'd127;
         default: return 7'($urandom_range(1, 127));
      endcase
   endfunction

   // mostly pushes, a few clears, now and then a long run of one extreme
   task automatic random_word();
      cmd_type            cmd;
      logic signed [15:0] smp;
      cmd = CMD_PUSH;
      if (burst_left > 0) begin
         smp = burst_val;
         burst_left--;
      end else begin
         if ($urandom_range(99) < 3) cmd = CMD_CLEAR;
         if ($urandom_range(99) == 0) begin
            burst_left = $urandom_range(60, 90);
            burst_val  = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
         end
         case ($urandom_range(9))
            0:       smp = 16'sh7fff;
            1:       smp = 16'sh8000;
            2:       smp = 16'($signed($urandom_range(8)) - 4);
            default: smp = 16'($urandom);
         endcase
      end
      send_word(cmd, smp);
   endtask

   task automatic test_random_traffic(int sgap, int rgap, int segments, int per_seg);
      send_gap_pct = sgap;
      rsp_gap_pct  = rgap;
      for (int s = 0; s < segments; s++) begin
         write_window(pick_window());
         burst_left = 0;
         for (int i = 0; i < per_seg; i++) random_word();
      end
   endtask

   // run limit
   initial begin : watchdog
      #2000000;
      $display("TB_ERROR");
      $finish;
   end

   // test sequence
   initial begin : main_seq
      win_model = WINDOW_RESET;
      clear_model();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_sample_extremes();
      test_window_register();
      test_backpressure();
      test_random_traffic(22, 59, 3, 161);
      test_random_traffic(59, 22, 3, 161);
      test_random_traffic(0, 0, 3, 161);
      wait_drain();

      $display("sent %0d words (%0d clears), checked %0d means", words_sent, clears_sent,
               results_seen);
      $display("window length written %0d times, incl. 0, 3, 64, 65 and 127",
               settings_used);
      if (err_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

>>> moving_average_filter_core.f
rtl/core/mavg_pkg.sv
rtl/core/mavg_ring.sv
rtl/core/mavg_div.sv
rtl/core/moving_average_filter_core.sv
test/tb_top.sv
